/* src/crcu_pkg.sv */
// Shared constants, types and the saturating helper function of the Cartesian rank/coordinate unit.
package crcu_pkg;

	localparam int MAX_DIMS   = 4;
	localparam int RANK_W     = 16;
	localparam int EXT_W      = 16;
	localparam int PRE_W      = EXT_W + 1;
	localparam int PROD_W     = PRE_W + EXT_W;
	localparam int DIST_W     = 9;
	localparam int AXIS_W     = 2;
	localparam int ND_W       = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int DIV_STAGES = RANK_W;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE0    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE1    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE2    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE3    = 3'd4;

	localparam logic [PRE_W-1:0] PRE_SAT = PRE_W'(1) << RANK_W;

	typedef enum logic [1:0] {
		CMD_TO_COORD = 2'd0,
		CMD_TO_RANK  = 2'd1,
		CMD_SHIFT    = 2'd2,
		CMD_NONE     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_AXIS     = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	// Clamped dimension count, extents with zero read as one, and prefix
	// products of the extents saturated at 2^16.
	typedef struct packed {
		logic [ND_W-1:0]                   nd;
		logic [MAX_DIMS-1:0][EXT_W-1:0]    ext;
		logic [MAX_DIMS:0][PRE_W-1:0]      pre;
	} cfg_t;

	typedef struct packed {
		cmd_t                              cmd;
		logic [RANK_W-1:0]                 rank;
		logic [AXIS_W-1:0]                 axis;
		logic                              neg;
		logic                              axis_bad;
		logic [MAX_DIMS-1:0][RANK_W-1:0]   coord;
	} side_t;

	function automatic logic [PRE_W-1:0] sat_pre(input logic [PROD_W-1:0] p);
		logic [PRE_W-1:0] r;
		r = (p > PROD_W'(PRE_SAT)) ? PRE_SAT : p[PRE_W-1:0];
		return r;
	endfunction

endpackage

/* src/crcu_in_if.sv */
// Request channel of the Cartesian rank/coordinate unit.
interface crcu_in_if;
	import crcu_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [1:0]               command;
	logic [RANK_W-1:0]        rank_in;
	logic [AXIS_W-1:0]        axis;
	logic signed [DIST_W-1:0] distance;
	logic [RANK_W-1:0]        coord_in0;
	logic [RANK_W-1:0]        coord_in1;
	logic [RANK_W-1:0]        coord_in2;
	logic [RANK_W-1:0]        coord_in3;

	modport source (output valid, command, rank_in, axis, distance,
		coord_in0, coord_in1, coord_in2, coord_in3, input ready);
	modport sink (input valid, command, rank_in, axis, distance,
		coord_in0, coord_in1, coord_in2, coord_in3, output ready);
endinterface

/* src/crcu_out_if.sv */
// Response channel of the Cartesian rank/coordinate unit.
interface crcu_out_if;
	import crcu_pkg::*;
	logic              valid;
	logic              ready;
	logic [RANK_W-1:0] rank_out;
	logic [RANK_W-1:0] source_rank;
	logic [RANK_W-1:0] dest_rank;
	logic [RANK_W-1:0] coord_out0;
	logic [RANK_W-1:0] coord_out1;
	logic [RANK_W-1:0] coord_out2;
	logic [RANK_W-1:0] coord_out3;
	logic [1:0]        status;

	modport source (output valid, rank_out, source_rank, dest_rank, coord_out0,
		coord_out1, coord_out2, coord_out3, status, input ready);
	modport sink (input valid, rank_out, source_rank, dest_rank, coord_out0,
		coord_out1, coord_out2, coord_out3, status, output ready);
endinterface

/* src/crcu_cfg.sv */
// Configuration registers and the registered chain of saturated prefix products.
module crcu_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [crcu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [crcu_pkg::CFG_DATA_W-1:0] cfg_data,
	output crcu_pkg::cfg_t                   cfg
);
	import crcu_pkg::*;

	logic [ND_W-1:0]                num_dims_q;
	logic [MAX_DIMS-1:0][EXT_W-1:0] size_q;
	logic [MAX_DIMS:2][PRE_W-1:0]   pre_q;
	logic [MAX_DIMS-1:0][EXT_W-1:0] ext;
	logic [MAX_DIMS:0][PRE_W-1:0]   pre;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_dims_q <= ND_W'(1);
			for (int n = 0; n < MAX_DIMS; n++) size_q[n] <= EXT_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUM_DIMS: num_dims_q <= cfg_data[ND_W-1:0];
				REG_SIZE0:    size_q[0]  <= cfg_data[EXT_W-1:0];
				REG_SIZE1:    size_q[1]  <= cfg_data[EXT_W-1:0];
				REG_SIZE2:    size_q[2]  <= cfg_data[EXT_W-1:0];
				REG_SIZE3:    size_q[3]  <= cfg_data[EXT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int n = 0; n < MAX_DIMS; n++) begin
			ext[n] = (size_q[n] == '0) ? EXT_W'(1) : size_q[n];
		end
		pre[0] = PRE_W'(1);
		pre[1] = PRE_W'(ext[0]);
		for (int k = 2; k <= MAX_DIMS; k++) pre[k] = pre_q[k];
	end

	// One multiplier per link; the chain settles link by link after a write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 2; k <= MAX_DIMS; k++) pre_q[k] <= PRE_W'(1);
		end else begin
			for (int k = 2; k <= MAX_DIMS; k++) begin
				pre_q[k] <= sat_pre(PROD_W'(pre[k-1]) * PROD_W'(ext[k-1]));
			end
		end
	end

	always_comb begin
		cfg.ext = ext;
		cfg.pre = pre;
		if (num_dims_q == '0) cfg.nd = ND_W'(1);
		else if (num_dims_q > ND_W'(MAX_DIMS)) cfg.nd = ND_W'(MAX_DIMS);
		else cfg.nd = num_dims_q;
	end
endmodule

/* src/crcu_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
module crcu_div (
	input  logic                         clk,
	input  logic                         en,
	input  logic [crcu_pkg::RANK_W-1:0]  dividend,
	input  logic [crcu_pkg::PRE_W-1:0]   divisor,
	output logic [crcu_pkg::RANK_W-1:0]  quotient,
	output logic [crcu_pkg::RANK_W-1:0]  remainder
);
	import crcu_pkg::*;

	logic [RANK_W-1:0] rem_s [DIV_STAGES];
	logic [RANK_W-1:0] num_s [DIV_STAGES];
	logic [PRE_W-1:0]  dvs_s [DIV_STAGES];

	genvar k;
	generate
		for (k = 0; k < DIV_STAGES; k++) begin : g_stage
			logic [RANK_W-1:0] rem_in;
			logic [RANK_W-1:0] num_in;
			logic [PRE_W-1:0]  dvs_in;
			logic [PRE_W-1:0]  trial;
			logic              fit;

			if (k == 0) begin : g_first
				assign rem_in = '0;
				assign num_in = dividend;
				assign dvs_in = divisor;
			end else begin : g_next
				assign rem_in = rem_s[k-1];
				assign num_in = num_s[k-1];
				assign dvs_in = dvs_s[k-1];
			end

			assign trial = {rem_in, num_in[RANK_W-1]};
			assign fit   = (trial >= dvs_in);

			// Dividend bits leave at the top while quotient bits enter at the bottom.
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= fit ? RANK_W'(trial - dvs_in) : trial[RANK_W-1:0];
					num_s[k] <= {num_in[RANK_W-2:0], fit};
					dvs_s[k] <= dvs_in;
				end
			end
		end
	endgenerate

	assign quotient  = num_s[DIV_STAGES-1];
	assign remainder = rem_s[DIV_STAGES-1];
endmodule

/* src/crcu_post.sv */
// Three stages after the dividers: products, differences, and final ranks and result word.
module crcu_post (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        en,
	input  crcu_pkg::cfg_t                              cfg,
	input  logic                                        in_vld,
	input  crcu_pkg::side_t                             side,
	input  logic [crcu_pkg::MAX_DIMS:0][crcu_pkg::RANK_W-1:0] quo,
	input  logic [crcu_pkg::RANK_W-1:0]                 srem,
	output logic                                        out_vld,
	crcu_out_if.source                                  rsp
);
	import crcu_pkg::*;

	localparam int W34 = PROD_W + 1;

	// Stage 1: multiplications.
	logic                                 vld_s1;
	side_t                                side_s1;
	logic [MAX_DIMS:0][RANK_W-1:0]        quo_s1;
	logic [MAX_DIMS-1:0][2*EXT_W-1:0]     cprod_s1;
	logic [MAX_DIMS-1:0][PROD_W-1:0]      term_s1;
	logic [PROD_W-1:0]                    step_s1;
	logic [PROD_W-1:0]                    dmod_s1;
	logic [PROD_W-1:0]                    qp_s1;
	logic                                 dsat_s1;
	logic                                 snz_s1;

	// Stage 2: differences and sums.
	logic                                 vld_s2;
	side_t                                side_s2;
	logic [MAX_DIMS-1:0][RANK_W-1:0]      coord_s2;
	logic [RANK_W-1:0]                    rsum_s2;
	logic                                 rovf_s2;
	logic [RANK_W-1:0]                    off_s2;
	logic [RANK_W-1:0]                    base_s2;
	logic [PROD_W-1:0]                    step_s2;
	logic [PROD_W-1:0]                    rest_s2;
	logic                                 sovf_s2;

	// Stage 3: result word.
	logic                                 vld_s3;
	logic [RANK_W-1:0]                    rank_s3;
	logic [RANK_W-1:0]                    src_s3;
	logic [RANK_W-1:0]                    dst_s3;
	logic [MAX_DIMS-1:0][RANK_W-1:0]      coord_s3;
	status_t                              status_s3;

	logic [RANK_W-1:0]                    rank_nx;
	logic [RANK_W-1:0]                    src_nx;
	logic [RANK_W-1:0]                    dst_nx;
	logic [MAX_DIMS-1:0][RANK_W-1:0]      coord_nx;
	status_t                              status_nx;

	logic [AXIS_W:0]   axis_w;
	logic [AXIS_W:0]   axis_up;
	logic [RANK_W+2:0] sum_w;
	logic              term_big;
	logic [W34-1:0]    off_w;
	logic [W34-1:0]    src_w;
	logic [W34-1:0]    dst_w;
	logic              shift_ovf;

	assign axis_w  = (AXIS_W+1)'(side.axis);
	assign axis_up = axis_w + (AXIS_W+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side;
			quo_s1  <= quo;
			for (int n = 0; n < MAX_DIMS; n++) begin
				cprod_s1[n] <= (2*EXT_W)'(cfg.ext[n]) * (2*EXT_W)'(quo[n+1]);
				term_s1[n]  <= PROD_W'(cfg.pre[n]) * PROD_W'(side.coord[n]);
			end
			step_s1 <= PROD_W'(cfg.pre[axis_w]) * PROD_W'(srem);
			dmod_s1 <= PROD_W'(cfg.pre[axis_w]) * PROD_W'(cfg.ext[side.axis]);
			qp_s1   <= PROD_W'(cfg.pre[axis_up]) * PROD_W'(quo[axis_up]);
			dsat_s1 <= cfg.pre[axis_w][PRE_W-1];
			snz_s1  <= (srem != '0);
		end
	end

	always_comb begin
		sum_w    = '0;
		term_big = 1'b0;
		for (int n = 0; n < MAX_DIMS; n++) begin
			sum_w    = sum_w + (RANK_W+3)'(term_s1[n][RANK_W-1:0]);
			term_big = term_big | (term_s1[n][PROD_W-1:RANK_W] != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_s1;
			for (int n = 0; n < MAX_DIMS; n++) begin
				coord_s2[n] <= (ND_W'(n) < cfg.nd) ?
					RANK_W'(quo_s1[n] - cprod_s1[n][RANK_W-1:0]) : '0;
			end
			rsum_s2 <= sum_w[RANK_W-1:0];
			rovf_s2 <= term_big | (sum_w[RANK_W+2:RANK_W] != '0);
			off_s2  <= RANK_W'(side_s1.rank - qp_s1[RANK_W-1:0]);
			base_s2 <= qp_s1[RANK_W-1:0];
			// A negative distance steps forward by the complement within the axis.
			if (side_s1.neg && snz_s1) begin
				step_s2 <= PROD_W'(dmod_s1 - step_s1);
				rest_s2 <= step_s1;
			end else begin
				step_s2 <= step_s1;
				rest_s2 <= PROD_W'(dmod_s1 - step_s1);
			end
			sovf_s2 <= dsat_s1 & snz_s1;
		end
	end

	always_comb begin
		off_w = W34'(off_s2);
		if (off_w >= W34'(step_s2)) src_w = off_w - W34'(step_s2);
		else src_w = off_w + W34'(rest_s2);
		if (off_w >= W34'(rest_s2)) dst_w = off_w - W34'(rest_s2);
		else dst_w = off_w + W34'(step_s2);
		src_w = src_w + W34'(base_s2);
		dst_w = dst_w + W34'(base_s2);
		shift_ovf = sovf_s2 | (src_w[W34-1:RANK_W] != '0) | (dst_w[W34-1:RANK_W] != '0);
	end

	always_comb begin
		rank_nx   = '0;
		src_nx    = '0;
		dst_nx    = '0;
		coord_nx  = '0;
		status_nx = ST_OK;
		case (side_s2.cmd)
			CMD_TO_COORD: coord_nx = coord_s2;
			CMD_TO_RANK: begin
				if (rovf_s2) status_nx = ST_OVERFLOW;
				else rank_nx = rsum_s2;
			end
			CMD_SHIFT: begin
				if (side_s2.axis_bad) status_nx = ST_AXIS;
				else if (shift_ovf) status_nx = ST_OVERFLOW;
				else begin
					src_nx = src_w[RANK_W-1:0];
					dst_nx = dst_w[RANK_W-1:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rank_s3   <= rank_nx;
			src_s3    <= src_nx;
			dst_s3    <= dst_nx;
			coord_s3  <= coord_nx;
			status_s3 <= status_nx;
		end
	end

	assign out_vld         = vld_s3;
	assign rsp.valid       = vld_s3;
	assign rsp.rank_out    = rank_s3;
	assign rsp.source_rank = src_s3;
	assign rsp.dest_rank   = dst_s3;
	assign rsp.coord_out0  = coord_s3[0];
	assign rsp.coord_out1  = coord_s3[1];
	assign rsp.coord_out2  = coord_s3[2];
	assign rsp.coord_out3  = coord_s3[3];
	assign rsp.status      = status_s3;
endmodule

/* src/cartesian_rank_coordinate_unit.sv */
// Top level of the Cartesian rank/coordinate unit.
//
// Requests arrive on req (valid/ready) with a command, a rank, an axis, a signed
// distance and four coordinates; each request word yields exactly one response
// word on rsp. Command 0 splits a rank into coordinates, command 1 folds
// coordinates into a rank, command 2 gives the source and destination ranks of
// a periodic shift, and command 3 gives an all-zero response.
// Grid registers are written on the cfg_we/cfg_index/cfg_data port; the user must
// write them only while no request is in flight, as the block does not enforce it.
// A request passes through twenty-two register stages: three front stages,
// sixteen divider stages (one quotient bit each, five dividers side by side
// giving the rank over every prefix product and the distance modulo the axis
// extent), and three stages of multiply, subtract and final select. One word is
// taken every cycle while the pipeline advances. When rsp.ready is low with a
// word waiting, the whole pipeline holds and req.ready drops; nothing is lost or
// repeated. Reset clears the valid bits and sets the registers to one dimension
// of extent one.
module cartesian_rank_coordinate_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [crcu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [crcu_pkg::CFG_DATA_W-1:0] cfg_data,
	crcu_in_if.sink                          req,
	crcu_out_if.source                       rsp
);
	import crcu_pkg::*;

	cfg_t                          cfg;
	logic                          adv;
	logic                          out_vld;
	side_t                         side_in;
	logic [DIST_W-1:0]             mag_in;
	logic [MAX_DIMS-1:0][RANK_W-1:0] coord_in;

	logic                          vld_s1, vld_s2, vld_s3;
	side_t                         side_s1, side_s2, side_s3;
	logic [DIST_W-1:0]             mag_s1, mag_s2, mag_s3;
	logic [EXT_W-1:0]              len_s1, len_s2, len_s3;

	logic                          dvld_s [DIV_STAGES];
	side_t                         dside_s [DIV_STAGES];

	logic [MAX_DIMS:0][RANK_W-1:0] quo;
	logic [RANK_W-1:0]             srem;
	logic [RANK_W-1:0]             srem_quo;

	assign adv       = !out_vld || rsp.ready;
	assign req.ready = adv;

	crcu_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	always_comb begin
		coord_in[0] = req.coord_in0;
		coord_in[1] = req.coord_in1;
		coord_in[2] = req.coord_in2;
		coord_in[3] = req.coord_in3;
		side_in.cmd      = cmd_t'(req.command);
		side_in.rank     = req.rank_in;
		side_in.axis     = req.axis;
		side_in.neg      = req.distance[DIST_W-1];
		side_in.axis_bad = (ND_W'(req.axis) >= cfg.nd);
		for (int n = 0; n < MAX_DIMS; n++) begin
			side_in.coord[n] = (ND_W'(n) < cfg.nd) ? coord_in[n] : '0;
		end
		mag_in = req.distance[DIST_W-1] ? DIST_W'(-req.distance) : DIST_W'(req.distance);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			for (int k = 0; k < DIV_STAGES; k++) dvld_s[k] <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			dvld_s[0] <= vld_s3;
			for (int k = 1; k < DIV_STAGES; k++) dvld_s[k] <= dvld_s[k-1];
		end
	end

	// Stages two and three also give the prefix-product chain time to settle
	// before the dividers sample it.
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side_in;
			mag_s1  <= mag_in;
			len_s1  <= cfg.ext[req.axis];
			side_s2 <= side_s1;
			mag_s2  <= mag_s1;
			len_s2  <= len_s1;
			side_s3 <= side_s2;
			mag_s3  <= mag_s2;
			len_s3  <= len_s2;
			dside_s[0] <= side_s3;
			for (int k = 1; k < DIV_STAGES; k++) dside_s[k] <= dside_s[k-1];
		end
	end

	genvar g;
	generate
		for (g = 1; g <= MAX_DIMS; g++) begin : g_lane
			logic [RANK_W-1:0] rem_unused;
			crcu_div u_div (
				.clk       (clk),
				.en        (adv),
				.dividend  (side_s3.rank),
				.divisor   (cfg.pre[g]),
				.quotient  (quo[g]),
				.remainder (rem_unused)
			);
		end
	endgenerate

	assign quo[0] = dside_s[DIV_STAGES-1].rank;

	crcu_div u_div_mod (
		.clk       (clk),
		.en        (adv),
		.dividend  (RANK_W'(mag_s3)),
		.divisor   (PRE_W'(len_s3)),
		.quotient  (srem_quo),
		.remainder (srem)
	);

	crcu_post u_post (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.cfg     (cfg),
		.in_vld  (dvld_s[DIV_STAGES-1]),
		.side    (dside_s[DIV_STAGES-1]),
		.quo     (quo),
		.srem    (srem),
		.out_vld (out_vld),
		.rsp     (rsp)
	);
endmodule

/* src/crcu_chk.sv */
// Port-level checks of the Cartesian rank/coordinate unit and their binding.
module crcu_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] status
);
	import crcu_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("response word dropped while stalled");

	a_status_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(status))
		else $error("status changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("request refused with the pipeline free to move");

	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("response word right after reset");
endmodule

bind cartesian_rank_coordinate_unit crcu_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (req.ready),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.status    (rsp.status)
);

/* bench/cartesian_rank_coordinate_unit_tb.sv */
// Self-checking testbench of the Cartesian rank/coordinate unit.
`timescale 1ns / 100ps

module cartesian_rank_coordinate_unit_tb;
	import crcu_pkg::*;

	typedef struct packed {
		logic [1:0]                      cmd;
		logic [RANK_W-1:0]               rank;
		logic [AXIS_W-1:0]               axis;
		logic signed [DIST_W-1:0]        shift_dist;
		logic [MAX_DIMS-1:0][RANK_W-1:0] coord;
	} query_t;

	typedef struct packed {
		logic [RANK_W-1:0]               rank_out;
		logic [RANK_W-1:0]               src;
		logic [RANK_W-1:0]               dst;
		logic [MAX_DIMS-1:0][RANK_W-1:0] coord;
		logic [1:0]                      status;
	} answer_t;

	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN      = 40;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	crcu_in_if  req ();
	crcu_out_if rsp ();

	cartesian_rank_coordinate_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req(req), .rsp(rsp)
	);

	// Testbench copy of the grid registers.
	logic [ND_W-1:0] grid_dims;
	logic [MAX_DIMS-1:0][EXT_W-1:0] grid_size;

	query_t  pending_q[$];
	answer_t answer_q[$];
	int send_idle;
	int recv_stall;
	int errors;
	int quiet_cycles;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int used_dims();
		int nd;
		nd = grid_dims;
		if (nd < 1) nd = 1;
		if (nd > MAX_DIMS) nd = MAX_DIMS;
		return nd;
	endfunction

	function automatic longint unsigned axis_extent(int n);
		return (grid_size[n] == 0) ? 64'd1 : 64'(grid_size[n]);
	endfunction

	function automatic answer_t predict_grid(query_t q);
		answer_t a;
		longint unsigned r, m, acc, d, len, dmod, base, off, mag, s, step, src, dst;
		longint dv;
		int nd;
		a = '0;
		nd = used_dims();
		case (q.cmd)
			CMD_TO_COORD: begin
				r = q.rank;
				for (int n = 0; n < nd; n++) begin
					a.coord[n] = RANK_W'(r % axis_extent(n));
					r = r / axis_extent(n);
				end
			end
			CMD_TO_RANK: begin
				m = 1;
				acc = 0;
				// Both terms saturate at 2^16, which already means overflow.
				for (int n = 0; n < nd; n++) begin
					acc = acc + m * 64'(q.coord[n]);
					if (acc > 64'h10000) acc = 64'h10000;
					m = m * axis_extent(n);
					if (m > 64'h10000) m = 64'h10000;
				end
				if (acc > 64'hFFFF) a.status = ST_OVERFLOW;
				else a.rank_out = RANK_W'(acc);
			end
			CMD_SHIFT: begin
				if (int'(q.axis) >= nd) begin
					a.status = ST_AXIS;
				end else begin
					d = 1;
					for (int n = 0; n < q.axis; n++) d = d * axis_extent(n);
					len = axis_extent(q.axis);
					dmod = d * len;
					base = (64'(q.rank) / dmod) * dmod;
					off = 64'(q.rank) - base;
					dv = q.shift_dist;
					mag = (dv < 0) ? -dv : dv;
					s = mag % len;
					if (dv < 0 && s != 0) s = len - s;
					step = s * d;
					src = (off >= step) ? off - step : off + (dmod - step);
					dst = (off >= dmod - step) ? off - (dmod - step) : off + step;
					src = src + base;
					dst = dst + base;
					if (src > 64'hFFFF || dst > 64'hFFFF) begin
						a.status = ST_OVERFLOW;
					end else begin
						a.src = RANK_W'(src);
						a.dst = RANK_W'(dst);
					end
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	// Driver: a new word goes out only once the current one has been taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!req.valid || req.ready) begin
				if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
					query_t q;
					q = pending_q.pop_front();
					req.command   <= q.cmd;
					req.rank_in   <= q.rank;
					req.axis      <= q.axis;
					req.distance  <= q.shift_dist;
					req.coord_in0 <= q.coord[0];
					req.coord_in1 <= q.coord[1];
					req.coord_in2 <= q.coord[2];
					req.coord_in3 <= q.coord[3];
					req.valid     <= 1'b1;
				end else begin
					req.valid <= 1'b0;
				end
			end
			rsp.ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	// Monitor: predicts on request acceptance, checks on response acceptance.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready) begin
				query_t q;
				q.cmd = req.command;
				q.rank = req.rank_in;
				q.axis = req.axis;
				q.shift_dist = req.distance;
				q.coord = {req.coord_in3, req.coord_in2, req.coord_in1, req.coord_in0};
				answer_q.push_back(predict_grid(q));
			end
			if (rsp.valid && rsp.ready) begin
				answer_t got;
				got = {rsp.rank_out, rsp.source_rank, rsp.dest_rank, rsp.coord_out3,
					rsp.coord_out2, rsp.coord_out1, rsp.coord_out0, rsp.status};
				if (answer_q.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual %p", $time, got);
					errors++;
				end else begin
					answer_t want;
					want = answer_q.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch, expected %p, actual %p", $time, want, got);
						errors++;
					end
				end
			end
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_NUM_DIMS) grid_dims = val[ND_W-1:0];
		else grid_size[idx - 1] = val[EXT_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_grid(int nd, int s0, int s1, int s2, int s3);
		write_reg(REG_NUM_DIMS, CFG_DATA_W'(nd));
		write_reg(REG_SIZE0, CFG_DATA_W'(s0));
		write_reg(REG_SIZE1, CFG_DATA_W'(s1));
		write_reg(REG_SIZE2, CFG_DATA_W'(s2));
		write_reg(REG_SIZE3, CFG_DATA_W'(s3));
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_q.size() != 0 || req.valid || answer_q.size() != 0);
		repeat (DRAIN) @(negedge clk);
	endtask

	function automatic query_t make_query(logic [1:0] cmd, int rank, int axis,
			int shift_dist, int c0, int c1, int c2, int c3);
		query_t q;
		q.cmd = cmd;
		q.rank = RANK_W'(rank);
		q.axis = AXIS_W'(axis);
		q.shift_dist = DIST_W'(shift_dist);
		q.coord = {RANK_W'(c3), RANK_W'(c2), RANK_W'(c1), RANK_W'(c0)};
		return q;
	endfunction

	function automatic query_t random_query();
		query_t q;
		longint unsigned cells;
		int pick;
		cells = 1;
		for (int n = 0; n < used_dims(); n++) cells = cells * axis_extent(n);
		if (cells > 65536) cells = 65536;
		pick = $urandom_range(99);
		q.cmd = (pick < 32) ? CMD_TO_COORD : (pick < 64) ? CMD_TO_RANK :
			(pick < 95) ? CMD_SHIFT : CMD_NONE;
		q.rank = ($urandom_range(9) < 8) ? RANK_W'($urandom_range(int'(cells) - 1)) :
			RANK_W'($urandom_range(65535));
		q.axis = AXIS_W'($urandom_range(3));
		q.shift_dist = DIST_W'(int'($urandom_range(510)) - 255);
		for (int n = 0; n < MAX_DIMS; n++) begin
			if ($urandom_range(9) < 8)
				q.coord[n] = RANK_W'($urandom_range(int'(axis_extent(n)) - 1));
			else
				q.coord[n] = RANK_W'($urandom_range(65535));
		end
		return q;
	endfunction

	int grids[8][5] = '{
		'{2, 4, 3, 1, 1}, '{4, 65535, 65535, 65535, 65535}, '{0, 7, 9, 2, 2},
		'{7, 2, 3, 5, 7}, '{3, 16, 0, 16, 9}, '{4, 0, 5, 7, 3},
		'{1, 65535, 1, 1, 1}, '{4, 1, 256, 1, 255}
	};

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req.valid = 1'b0;
		req.command = '0;
		req.rank_in = '0;
		req.axis = '0;
		req.distance = '0;
		req.coord_in0 = '0;
		req.coord_in1 = '0;
		req.coord_in2 = '0;
		req.coord_in3 = '0;
		rsp.ready = 1'b0;
		send_idle = 0;
		recv_stall = 0;
		errors = 0;
		quiet_cycles = 0;
		grid_dims = 1;
		grid_size = {4{EXT_W'(1)}};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// A few words on the reset grid, the directed set on a 3x4x5x6 grid, then three on a 5x5 grid.
		pending_q.push_back(make_query(CMD_TO_COORD, 65535, 0, 0, 0, 0, 0, 0));
		pending_q.push_back(make_query(CMD_SHIFT, 9, 0, 1, 0, 0, 0, 0));
		wait_drained();
		set_grid(4, 3, 4, 5, 6);
		pending_q.push_back(make_query(CMD_TO_COORD, 0, 0, 0, 0, 0, 0, 0));
		pending_q.push_back(make_query(CMD_TO_COORD, 359, 0, 0, 0, 0, 0, 0));
		pending_q.push_back(make_query(CMD_TO_COORD, 65535, 3, -255, 0, 0, 0, 0));
		pending_q.push_back(make_query(CMD_TO_RANK, 0, 0, 0, 0, 0, 0, 0));
		pending_q.push_back(make_query(CMD_TO_RANK, 0, 0, 0, 2, 3, 4, 5));
		pending_q.push_back(make_query(CMD_TO_RANK, 0, 0, 0, 7, 0, 9, 1));
		pending_q.push_back(make_query(CMD_TO_RANK, 0, 0, 0, 65535, 65535, 65535, 65535));
		pending_q.push_back(make_query(CMD_TO_RANK, 65535, 3, 255, 65535, 0, 0, 0));
		pending_q.push_back(make_query(CMD_TO_RANK, 0, 0, 0, 0, 0, 0, 182));
		pending_q.push_back(make_query(CMD_SHIFT, 0, 0, 255, 0, 0, 0, 0));
		pending_q.push_back(make_query(CMD_SHIFT, 0, 0, -255, 0, 0, 0, 0));
		pending_q.push_back(make_query(CMD_SHIFT, 359, 1, -1, 0, 0, 0, 0));
		pending_q.push_back(make_query(CMD_SHIFT, 200, 2, 0, 0, 0, 0, 0));
		pending_q.push_back(make_query(CMD_SHIFT, 359, 3, 1, 0, 0, 0, 0));
		pending_q.push_back(make_query(CMD_SHIFT, 65535, 3, 7, 0, 0, 0, 0));
		pending_q.push_back(make_query(CMD_SHIFT, 65535, 0, -256, 0, 0, 0, 0));
		pending_q.push_back(make_query(CMD_NONE, 65535, 3, -1, 65535, 65535, 65535, 65535));
		wait_drained();
		set_grid(2, 5, 5, 5, 5);
		pending_q.push_back(make_query(CMD_SHIFT, 12, 2, 3, 0, 0, 0, 0));
		pending_q.push_back(make_query(CMD_SHIFT, 12, 3, 3, 0, 0, 0, 0));
		pending_q.push_back(make_query(CMD_TO_RANK, 0, 0, 0, 4, 4, 65535, 65535));
		wait_drained();

		for (int ph = 0; ph < 8; ph++) begin
			set_grid(grids[ph][0], grids[ph][1], grids[ph][2], grids[ph][3], grids[ph][4]);
			case (ph % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 57; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 57; end
				default: begin send_idle = 8; recv_stall = 8; end
			endcase
			for (int i = 0; i < 235; i++) pending_q.push_back(random_query());
			wait_drained();
		end

		if (errors == 0 && answer_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
